FILE: rtl/core/rmmn_pkg.sv
// Shared constants, types and job encoding for the RGB min-max normalizer.
package rmmn_pkg;

   localparam int SAMPLE_WIDTH           = 24;
   localparam int QUOTIENT_FRACTION_BITS = 16;
   localparam int NUM_CHANNELS           = 3;

   localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int NORM_WIDTH  = QUOTIENT_FRACTION_BITS + 1;
   localparam int COUNT_WIDTH = $clog2(QUOTIENT_FRACTION_BITS);
   localparam int CHAN_WIDTH  = $clog2(NUM_CHANNELS);

   localparam int REQ_DATA_WIDTH = ((NUM_CHANNELS * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int REQ_USER_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = ((NUM_CHANNELS * NORM_WIDTH + 7) / 8) * 8;
   localparam int RSP_USER_WIDTH = NUM_CHANNELS;

   localparam int USER_OP_BIT        = 0;
   localparam int USER_NEW_FRAME_BIT = 1;

   localparam int QPTR_WIDTH   = 1;
   localparam int QUEUE_DEPTH  = 1 << QPTR_WIDTH;
   localparam int QCOUNT_WIDTH = QPTR_WIDTH + 1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [NORM_WIDTH-1:0]          norm_type;

   localparam sample_type SAMPLE_MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam norm_type   NORM_ONE        = {1'b1, {QUOTIENT_FRACTION_BITS{1'b0}}};
   localparam norm_type   NORM_ZERO       = '0;

   // How one channel of a normalize beat is resolved.
   typedef enum logic [1:0] {
      KIND_FLAT,
      KIND_ZERO,
      KIND_ONE,
      KIND_DIV
   } scale_kind_type;

   typedef struct packed {
      scale_kind_type          kind;
      logic [DIFF_WIDTH-1:0]   num;
      logic [DIFF_WIDTH-1:0]   den;
   } chan_job_type;

   typedef struct packed {
      chan_job_type [NUM_CHANNELS-1:0] chan;
   } job_type;

endpackage

FILE: rtl/core/rmmn_front.sv
// Front end: accepts beats, tracks per-channel extremes and classifies normalize beats.
module rmmn_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rmmn_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [rmmn_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   input  logic                                q_full,
   output logic                                q_push,
   output rmmn_pkg::job_type                   q_job
);
   import rmmn_pkg::*;

   sample_type              sample   [NUM_CHANNELS];
   sample_type              low_ff   [NUM_CHANNELS];
   sample_type              low_in   [NUM_CHANNELS];
   sample_type              high_ff  [NUM_CHANNELS];
   sample_type              high_in  [NUM_CHANNELS];
   logic signed [DIFF_WIDTH-1:0] num_s [NUM_CHANNELS];
   logic signed [DIFF_WIDTH-1:0] den_s [NUM_CHANNELS];
   logic                    accept;
   logic                    measure;
   logic                    restart;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign measure    = accept && !req_tuser[USER_OP_BIT];
   assign restart    = req_tuser[USER_NEW_FRAME_BIT];
   assign q_push     = accept && req_tuser[USER_OP_BIT];

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sample[c]  = req_tdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH];
         low_in[c]  = low_ff[c];
         high_in[c] = high_ff[c];
         if (measure) begin
            if (restart) begin
               low_in[c]  = sample[c];
               high_in[c] = sample[c];
            end else begin
               if (sample[c] < low_ff[c]) begin
                  low_in[c] = sample[c];
               end
               if (sample[c] > high_ff[c]) begin
                  high_in[c] = sample[c];
               end
            end
         end

         // Both differences are taken one bit wider so they never overflow.
         num_s[c] = {sample[c][SAMPLE_WIDTH-1], sample[c]}
                  - {low_ff[c][SAMPLE_WIDTH-1], low_ff[c]};
         den_s[c] = {high_ff[c][SAMPLE_WIDTH-1], high_ff[c]}
                  - {low_ff[c][SAMPLE_WIDTH-1], low_ff[c]};
         q_job.chan[c].num = num_s[c];
         q_job.chan[c].den = den_s[c];
         if (high_ff[c] <= low_ff[c]) begin
            q_job.chan[c].kind = KIND_FLAT;
         end else if (sample[c] <= low_ff[c]) begin
            q_job.chan[c].kind = KIND_ZERO;
         end else if (sample[c] >= high_ff[c]) begin
            q_job.chan[c].kind = KIND_ONE;
         end else begin
            q_job.chan[c].kind = KIND_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (reset) begin
            low_ff[c]  <= SAMPLE_MOST_POS;
            high_ff[c] <= SAMPLE_MOST_NEG;
         end else begin
            low_ff[c]  <= low_in[c];
            high_ff[c] <= high_in[c];
         end
      end
   end

endmodule

FILE: rtl/core/rmmn_queue.sv
// Small job queue between the classifying front end and the divider back end.
module rmmn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rmmn_pkg::job_type job_in,
   input  logic              pop,
   output logic              valid,
   output logic              full,
   output rmmn_pkg::job_type job_out
);
   import rmmn_pkg::*;

   job_type                 entry_ff  [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]   wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QPTR_WIDTH-1:0]   rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0] count_ff;
   logic [QCOUNT_WIDTH-1:0] count_in;
   logic                    do_push;
   logic                    do_pop;

   assign valid   = count_ff != '0;
   assign full    = count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH);
   assign job_out = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

FILE: rtl/core/rmmn_back.sv
// Back end: shared restoring divider over the three channels and the result register.
module rmmn_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  rmmn_pkg::job_type                   q_job,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rmmn_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [rmmn_pkg::RSP_USER_WIDTH-1:0] rsp_tuser
);
   import rmmn_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   job_type                            job_ff;
   job_type                            job_in;
   logic [CHAN_WIDTH-1:0]              chan_ff;
   logic [CHAN_WIDTH-1:0]              chan_in;
   logic [COUNT_WIDTH-1:0]             cnt_ff;
   logic [COUNT_WIDTH-1:0]             cnt_in;
   logic [DIFF_WIDTH-1:0]              rem_ff;
   logic [DIFF_WIDTH-1:0]              rem_in;
   logic [DIFF_WIDTH-1:0]              den_ff;
   logic [DIFF_WIDTH-1:0]              den_in;
   logic [QUOTIENT_FRACTION_BITS-1:0]  quot_ff;
   logic [QUOTIENT_FRACTION_BITS-1:0]  quot_in;
   norm_type                           res_ff [NUM_CHANNELS];
   norm_type                           res_in [NUM_CHANNELS];
   logic                               out_valid_ff;
   logic                               out_valid_in;
   norm_type                           out_norm_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]            out_flat_ff;
   logic [NUM_CHANNELS-1:0]            flat_bits;

   chan_job_type                       cur;
   logic [DIFF_WIDTH:0]                rem_shift;
   logic [DIFF_WIDTH:0]                rem_sub;
   logic                               quot_bit;
   logic                               last_chan;
   logic                               last_step;
   logic                               emit_ok;

   assign cur       = job_ff.chan[chan_ff];
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign quot_bit  = rem_shift >= {1'b0, den_ff};
   assign last_chan = chan_ff == CHAN_WIDTH'(NUM_CHANNELS - 1);
   assign last_step = cnt_ff == COUNT_WIDTH'(QUOTIENT_FRACTION_BITS - 1);
   assign emit_ok   = !out_valid_ff || rsp_tready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         flat_bits[c] = job_ff.chan[c].kind == KIND_FLAT;
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      chan_in  = chan_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         res_in[c] = res_ff[c];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               job_in   = q_job;
               chan_in  = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // Only an interior value needs the divider; the rest resolve here.
            if (cur.kind == KIND_DIV) begin
               rem_in   = cur.num;
               den_in   = cur.den;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               res_in[chan_ff] = (cur.kind == KIND_ONE) ? NORM_ONE : NORM_ZERO;
               if (last_chan) begin
                  state_in = ST_EMIT;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end
         ST_DIV: begin
            rem_in  = quot_bit ? rem_sub[DIFF_WIDTH-1:0] : rem_shift[DIFF_WIDTH-1:0];
            quot_in = {quot_ff[QUOTIENT_FRACTION_BITS-2:0], quot_bit};
            cnt_in  = cnt_ff + 1'b1;
            if (last_step) begin
               res_in[chan_ff] = {1'b0, quot_ff[QUOTIENT_FRACTION_BITS-2:0], quot_bit};
               if (last_chan) begin
                  state_in = ST_EMIT;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if ((state_ff == ST_EMIT) && emit_ok) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      chan_ff <= chan_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         res_ff[c] <= res_in[c];
      end
      if ((state_ff == ST_EMIT) && emit_ok) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            out_norm_ff[c] <= res_ff[c];
         end
         out_flat_ff <= flat_bits;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_flat_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({out_norm_ff[2], out_norm_ff[1], out_norm_ff[0]});

endmodule

FILE: rtl/core/rgb_min_max_normalizer_unit.sv
// Measure beats (tuser op bit low) update the per-channel minimum and maximum and are
// taken one per cycle while the job queue is not full; normalize beats yield one result
// of (value - min) / (max - min) per channel as unsigned Q1.16, clamped to 0 .. 1.0, with
// a range_zero bit per channel when max does not exceed min (that channel then reads 0).
// The extremes are sampled when a normalize beat is accepted, so a two-entry job queue
// lets later beats enter while a result is still being worked out. The back end owns one
// restoring divider that makes one quotient bit per cycle; a clamped or flat channel is
// resolved in setup without it. A finished result waits in the output register without
// holding up the divider.
module rgb_min_max_normalizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // red, green, blue (signed Q8.16 each), from bit 0 up
   input  logic [rmmn_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // op, new_frame, from bit 0 up
   input  logic [rmmn_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red_norm, green_norm, blue_norm (17 bits each), zero fill, from bit 0 up
   output logic [rmmn_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // range_zero (red, green, blue), from bit 0 up
   output logic [rmmn_pkg::RSP_USER_WIDTH-1:0] rsp_tuser
);
   import rmmn_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   logic    q_full;
   job_type push_job;
   job_type pop_job;

   rmmn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   rmmn_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (push_job),
      .pop     (q_pop),
      .valid   (q_valid),
      .full    (q_full),
      .job_out (pop_job)
   );

   rmmn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/core/rmmn_checker.sv
// Port-level checks for the RGB min-max normalizer and their binding to the top level.
module rmmn_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [rmmn_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic [rmmn_pkg::RSP_USER_WIDTH-1:0] rsp_tuser
);
   import rmmn_pkg::*;

   norm_type red_norm;
   norm_type green_norm;
   norm_type blue_norm;

   assign red_norm   = rsp_tdata[0*NORM_WIDTH +: NORM_WIDTH];
   assign green_norm = rsp_tdata[1*NORM_WIDTH +: NORM_WIDTH];
   assign blue_norm  = rsp_tdata[2*NORM_WIDTH +: NORM_WIDTH];

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed or dropped");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> red_norm <= NORM_ONE && green_norm <= NORM_ONE && blue_norm <= NORM_ONE)
      else $error("normalized value above 1.0");

   // A channel without usable range must read zero.
   a_flat_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser[0] || red_norm == NORM_ZERO)
                  && (!rsp_tuser[1] || green_norm == NORM_ZERO)
                  && (!rsp_tuser[2] || blue_norm == NORM_ZERO))
      else $error("flat channel with nonzero value");

endmodule

bind rgb_min_max_normalizer_unit rmmn_checker u_rmmn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/rgb_min_max_normalizer_unit_tb.sv
// Self-checking testbench for the RGB min-max normalizer: directed table, then random frames.
`timescale 1ns / 100ps

module rgb_min_max_normalizer_unit_tb;
   import rmmn_pkg::*;

   typedef enum logic {
      OP_MEASURE   = 1'b0,
      OP_NORMALIZE = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type           op;
      logic                  new_frame;
      sample_type [2:0]      chan;       // 0 red, 1 green, 2 blue
   } pixel_beat_type;

   typedef struct packed {
      norm_type [2:0]        norm;       // 0 red, 1 green, 2 blue
      logic [2:0]            range_zero;
   } norm_result_type;

   typedef struct packed {
      pixel_beat_type        px;
      bit                    has_lit;
      norm_result_type       lit;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [REQ_USER_WIDTH-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;

   // Typed-in expectation that travels with the beat currently on the request side.
   logic                      lit_valid = 1'b0;
   norm_result_type           lit_result = '0;

   bit                        quiet_phase = 1'b0;
   int                        rsp_hold = 0;
   int                        mismatch_count = 0;

   sample_type                low_val  [0:2];
   sample_type                high_val [0:2];
   norm_result_type           pending_norms [$];
   stim_row_type              directed_rows [$];

   rgb_min_max_normalizer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   function automatic sample_type any_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return SAMPLE_MOST_POS;
      if (r < 12) return SAMPLE_MOST_NEG;
      return sample_type'($urandom);
   endfunction

   function automatic sample_type near_sample(input sample_type base, input int unsigned spread);
      return base + sample_type'($urandom_range(0, spread));
   endfunction

   // Tracks extremes on measure beats; on normalize beats returns 1 with the scaled channels.
   function automatic bit apply_pixel(input pixel_beat_type px, output norm_result_type res);
      sample_type v;
      sample_type lo;
      sample_type hi;
      longint     num;
      longint     den;
      longint     quo;
      res = '0;
      for (int c = 0; c < 3; c++) begin
         v  = px.chan[c];
         lo = low_val[c];
         hi = high_val[c];
         if (px.op == OP_MEASURE) begin
            if (px.new_frame) begin
               low_val[c]  = v;
               high_val[c] = v;
            end else begin
               if (v < lo) low_val[c] = v;
               if (v > hi) high_val[c] = v;
            end
         end else if (hi <= lo) begin
            // An empty or inverted range reads as zero and raises the flag.
            res.norm[c]       = NORM_ZERO;
            res.range_zero[c] = 1'b1;
         end else if (v <= lo) begin
            res.norm[c] = NORM_ZERO;
         end else if (v >= hi) begin
            res.norm[c] = NORM_ONE;
         end else begin
            num = longint'(v) - longint'(lo);
            den = longint'(hi) - longint'(lo);
            quo = (num << QUOTIENT_FRACTION_BITS) / den;
            res.norm[c] = (quo > longint'(NORM_ONE)) ? NORM_ONE : norm_type'(quo);
         end
      end
      return px.op == OP_NORMALIZE;
   endfunction

   task automatic add_row(input op_kind_type op, input logic nf, input sample_type r,
                          input sample_type g, input sample_type b, input bit lit,
                          input norm_type er, input norm_type eg, input norm_type eb,
                          input logic [2:0] rz);
      stim_row_type row;
      row.px.op               = op;
      row.px.new_frame        = nf;
      row.px.chan[0]          = r;
      row.px.chan[1]          = g;
      row.px.chan[2]          = b;
      row.has_lit             = lit;
      row.lit.norm[0]         = er;
      row.lit.norm[1]         = eg;
      row.lit.norm[2]         = eb;
      row.lit.range_zero      = rz;
      directed_rows.push_back(row);
   endtask

   task automatic drive_pixel(input pixel_beat_type px, input bit has_lit,
                              input norm_result_type lit);
      int                        gap;
      logic [REQ_USER_WIDTH-1:0] user;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      user                     = '0;
      user[USER_OP_BIT]        = px.op;
      user[USER_NEW_FRAME_BIT] = px.new_frame;
      req_tvalid <= 1'b1;
      req_tdata  <= px.chan;
      req_tuser  <= user;
      lit_valid  <= has_lit;
      lit_result <= lit;
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         quiet_phase <= !quiet_phase;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= pick_gap();
         end
      end
   end

   // Every accepted request beat is run through the predictor at the edge that takes it.
   always @(posedge clock) begin : predict_blk
      pixel_beat_type  px;
      norm_result_type res;
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            low_val[c]  = SAMPLE_MOST_POS;
            high_val[c] = SAMPLE_MOST_NEG;
         end
      end else if (req_tvalid && req_tready) begin
         px.op        = op_kind_type'(req_tuser[USER_OP_BIT]);
         px.new_frame = req_tuser[USER_NEW_FRAME_BIT];
         px.chan      = req_tdata[3*SAMPLE_WIDTH-1:0];
         if (apply_pixel(px, res)) begin
            pending_norms.push_back(lit_valid ? lit_result : res);
         end
      end
   end

   always @(posedge clock) begin : check_blk
      norm_result_type got;
      norm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.norm       = rsp_tdata[3*NORM_WIDTH-1:0];
         got.range_zero = rsp_tuser;
         if (pending_norms.size() == 0) begin
            log_mismatch($sformatf("unexpected result beat: r=%0d g=%0d b=%0d zero=%b",
                                   got.norm[0], got.norm[1], got.norm[2], got.range_zero));
         end else begin
            want = pending_norms.pop_front();
            if (got.norm[0] != want.norm[0] || got.norm[1] != want.norm[1] ||
                got.norm[2] != want.norm[2] || got.range_zero != want.range_zero) begin
               log_mismatch($sformatf(
                  "result mismatch: expected r=%0d g=%0d b=%0d zero=%b, got r=%0d g=%0d b=%0d zero=%b",
                  want.norm[0], want.norm[1], want.norm[2], want.range_zero,
                  got.norm[0], got.norm[1], got.norm[2], got.range_zero));
            end
         end
      end
   end

   initial begin : stimulus_blk
      pixel_beat_type px;
      sample_type   base [0:2];
      int unsigned  spread [0:2];
      sample_type   seen [0:15][0:2];
      int           n_meas;
      int           n_norm;
      int           pick;
      int           beats_sent;
      int           waited;

      // Nothing measured yet, new_frame on a normalize beat, then flat channels.
      add_row(OP_NORMALIZE, 0, 0, 0, 0, 1, NORM_ZERO, NORM_ZERO, NORM_ZERO, 3'b111);
      add_row(OP_NORMALIZE, 1, SAMPLE_MOST_POS, SAMPLE_MOST_NEG, 0, 1,
              NORM_ZERO, NORM_ZERO, NORM_ZERO, 3'b111);
      add_row(OP_MEASURE, 1, SAMPLE_MOST_NEG, 0, SAMPLE_MOST_POS, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, SAMPLE_MOST_NEG, 0, SAMPLE_MOST_POS, 1,
              NORM_ZERO, NORM_ZERO, NORM_ZERO, 3'b111);
      // Full-scale ranges on red and blue, a narrow one on green.
      add_row(OP_MEASURE, 0, SAMPLE_MOST_POS, 100, SAMPLE_MOST_NEG, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, SAMPLE_MOST_POS, 100, SAMPLE_MOST_POS, 1,
              NORM_ONE, NORM_ONE, NORM_ONE, 3'b000);
      add_row(OP_NORMALIZE, 0, SAMPLE_MOST_NEG, 0, SAMPLE_MOST_NEG, 1,
              NORM_ZERO, NORM_ZERO, NORM_ZERO, 3'b000);
      add_row(OP_NORMALIZE, 0, 0, 50, 1, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, SAMPLE_MOST_POS - 1, 99, SAMPLE_MOST_NEG + 1, 0, 0, 0, 0, 0);
      // Restart, then values below min, above max and in between.
      add_row(OP_MEASURE, 1, 10, 20, 30, 0, 0, 0, 0, 0);
      add_row(OP_MEASURE, 0, 20, 40, 60, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, 5, 100, 45, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 1, 15, 30, -1, 0, 0, 0, 0, 0);
      add_row(OP_MEASURE, 0, 15, 30, 45, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, 20, 20, 30, 1, NORM_ONE, NORM_ZERO, NORM_ZERO, 3'b000);
      add_row(OP_MEASURE, 1, 7, 7, 7, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, 7, -7, 8, 1, NORM_ZERO, NORM_ZERO, NORM_ZERO, 3'b111);
      add_row(OP_MEASURE, 0, 8, 7, 7, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, 7, 7, 7, 1, NORM_ZERO, NORM_ZERO, NORM_ZERO, 3'b110);
      add_row(OP_NORMALIZE, 0, 8, 8, 8, 0, 0, 0, 0, 0);
      add_row(OP_MEASURE, 1, -1, SAMPLE_MOST_NEG, SAMPLE_MOST_NEG + 1, 0, 0, 0, 0, 0);
      add_row(OP_MEASURE, 0, 0, SAMPLE_MOST_NEG + 1, SAMPLE_MOST_POS, 0, 0, 0, 0, 0);
      add_row(OP_NORMALIZE, 0, -1, SAMPLE_MOST_POS, 0, 0, 0, 0, 0, 0);

      while (reset) @(posedge clock);

      foreach (directed_rows[i]) begin
         drive_pixel(directed_rows[i].px, directed_rows[i].has_lit, directed_rows[i].lit);
      end

      beats_sent = 0;
      while (beats_sent < 650) begin
         if ($urandom_range(0, 99) < 80) begin
            // A measure pass followed by a normalize pass over values of the same spread.
            n_meas = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
            n_norm = $urandom_range(1, 10);
            for (int c = 0; c < 3; c++) begin
               if ($urandom_range(0, 3) == 0) begin
                  base[c]   = any_sample();
                  spread[c] = 32'h00FF_FFFF;
               end else begin
                  base[c]   = sample_type'($urandom);
                  spread[c] = ($urandom_range(0, 9) == 0) ? 0
                              : (32'd1 << $urandom_range(0, 22)) - 1;
               end
            end
            for (int k = 0; k < n_meas; k++) begin
               px.op        = OP_MEASURE;
               px.new_frame = (k == 0) ? ($urandom_range(0, 19) != 0)
                                       : ($urandom_range(0, 29) == 0);
               for (int c = 0; c < 3; c++) begin
                  seen[k][c]  = near_sample(base[c], spread[c]);
                  px.chan[c]  = seen[k][c];
               end
               drive_pixel(px, 1'b0, '0);
               beats_sent++;
            end
            for (int k = 0; k < n_norm; k++) begin
               px.op        = OP_NORMALIZE;
               px.new_frame = 1'($urandom_range(0, 1));
               for (int c = 0; c < 3; c++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 40) begin
                     px.chan[c] = seen[$urandom_range(0, n_meas - 1)][c];
                  end else if (pick < 85) begin
                     px.chan[c] = near_sample(base[c] - sample_type'(spread[c] / 8),
                                              spread[c] + spread[c] / 4);
                  end else begin
                     px.chan[c] = any_sample();
                  end
               end
               drive_pixel(px, 1'b0, '0);
               beats_sent++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               px.op        = op_kind_type'($urandom_range(0, 1));
               px.new_frame = 1'($urandom_range(0, 1));
               for (int c = 0; c < 3; c++) begin
                  px.chan[c] = any_sample();
               end
               drive_pixel(px, 1'b0, '0);
               beats_sent++;
            end
         end
      end
      req_tvalid <= 1'b0;
      lit_valid  <= 1'b0;

      waited = 0;
      while (pending_norms.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      // Room for a stray result beat to show up after the last expected one.
      repeat (150) @(posedge clock);
      if (pending_norms.size() != 0) begin
         log_mismatch($sformatf("%0d expected results never arrived", pending_norms.size()));
      end

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rmmn_pkg.sv
rtl/core/rmmn_front.sv
rtl/core/rmmn_queue.sv
rtl/core/rmmn_back.sv
rtl/core/rgb_min_max_normalizer_unit.sv
rtl/core/rmmn_checker.sv
verif/rgb_min_max_normalizer_unit_tb.sv
